// File: rtl/core/dot_pkg.sv
// Package for the debounced occupancy toggle with timeout.
// Holds the item types, code constants, widths and register reset values.
// No dependencies; every other file imports it.
`default_nettype none

package dot_pkg;

  // Widths of state and configuration
  localparam int unsigned DebW     = 8;
  localparam int unsigned SteadyW  = 9;
  localparam int unsigned OccW     = 20;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned CfgIdxW  = 3;

  // Saturation limits of the two counters
  localparam logic [SteadyW-1:0] SteadyMax = {SteadyW{1'b1}};
  localparam logic [OccW-1:0]    OccMax    = {OccW{1'b1}};

  // Register reset values
  localparam logic [DebW-1:0] DebTicksRst     = 8'd20;
  localparam logic [OccW-1:0] TimeoutTicksRst = 20'd2000;

  // Register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE_TICKS = 3'd0,
    REG_TIMEOUT_TICKS  = 3'd1,
    REG_ALARM_ENABLE   = 3'd2,
    REG_RED_ENABLE     = 3'd3,
    REG_GREEN_ENABLE   = 3'd4
  } reg_idx_e;

  // Remote event codes
  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_IN   = 2'd1,
    MODE_OUT  = 2'd2
  } mode_e;

  // Announcement codes
  typedef enum logic [1:0] {
    ANN_NONE = 2'd0,
    ANN_IN   = 2'd1,
    ANN_OUT  = 2'd2
  } ann_e;

  // Button level
  localparam logic LevelReleased = 1'b1;
  localparam logic LevelPressed  = 1'b0;

  // Input item: one tick
  typedef struct packed {
    logic       button_level;
    logic [1:0] mode;
  } dot_in_t;

  // Result item
  typedef struct packed {
    logic       alarm_out;
    logic       red_out;
    logic       green_out;
    logic       occupied;
    logic [1:0] announce;
    logic       timeout_fired;
  } dot_out_t;

  // Lamp and alarm enables passed to the occupancy stage
  typedef struct packed {
    logic alarm_en;
    logic red_en;
    logic green_en;
  } dot_lamp_en_t;

endpackage

`default_nettype wire

// File: rtl/core/dot_debounce.sv
// Button debouncer: raw level tracking, steady counter and stable level.
// Depends on dot_pkg. Emits a one-tick press flag on a confirmed falling edge.
`default_nettype none

module dot_debounce
  import dot_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic            raw_i,
  input  wire logic [DebW-1:0] deb_ticks_i,
  output logic                 press_o
);

  logic               last_raw_q, last_raw_d;
  logic               stable_q, stable_d;
  logic [SteadyW-1:0] steady_q, steady_d;

  // Restart on a raw change, otherwise count up to saturation
  always_comb begin
    last_raw_d = last_raw_q;
    steady_d   = steady_q;
    if (raw_i != last_raw_q) begin
      last_raw_d = raw_i;
      steady_d   = '0;
    end else if (steady_q != SteadyMax) begin
      steady_d = steady_q + SteadyW'(1);
    end
  end

  // Accept the level once steady for strictly more than the threshold
  always_comb begin
    stable_d = stable_q;
    press_o  = 1'b0;
    if ((steady_d > {1'b0, deb_ticks_i}) && (raw_i != stable_q)) begin
      stable_d = raw_i;
      press_o  = (raw_i == LevelPressed);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= LevelReleased;
      stable_q   <= LevelReleased;
      steady_q   <= '0;
    end else if (step_i) begin
      last_raw_q <= last_raw_d;
      stable_q   <= stable_d;
      steady_q   <= steady_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dot_occupancy.sv
// Occupancy state, timeout counter and result item formation.
// Depends on dot_pkg. Takes the press flag from dot_debounce.
`default_nettype none

module dot_occupancy
  import dot_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic            press_i,
  input  wire logic [1:0]      mode_i,
  input  wire logic [OccW-1:0] timeout_ticks_i,
  input  wire dot_lamp_en_t    lamp_en_i,
  output dot_out_t             result_o
);

  logic            occ_q, occ_d;
  logic [OccW-1:0] cnt_q, cnt_d;
  logic [OccW-1:0] cnt_inc;
  logic            fired;
  logic [1:0]      ann;

  // Timeout check, then press toggle, then remote event
  always_comb begin
    occ_d   = occ_q;
    cnt_d   = cnt_q;
    cnt_inc = cnt_q;
    fired   = 1'b0;
    ann     = ANN_NONE;
    if (occ_q) begin
      if (cnt_q != OccMax) begin
        cnt_inc = cnt_q + OccW'(1);
      end
      cnt_d = cnt_inc;
      if (cnt_inc >= timeout_ticks_i) begin
        fired = 1'b1;
        occ_d = 1'b0;
        cnt_d = '0;
      end
    end
    if (!fired) begin
      if (press_i) begin
        occ_d = ~occ_q;
        ann   = occ_q ? ANN_OUT : ANN_IN;
        cnt_d = '0;
      end
      case (mode_i)
        MODE_IN: begin
          occ_d = 1'b1;
          ann   = ANN_IN;
          cnt_d = '0;
        end
        MODE_OUT: begin
          occ_d = 1'b0;
          ann   = ANN_OUT;
          cnt_d = '0;
        end
        default: ;
      endcase
    end
  end

  // Result item from the state after this tick
  always_comb begin
    result_o.alarm_out     = occ_d & lamp_en_i.alarm_en;
    result_o.red_out       = occ_d & lamp_en_i.red_en;
    result_o.green_out     = ~occ_d & lamp_en_i.green_en;
    result_o.occupied      = occ_d;
    result_o.announce      = ann;
    result_o.timeout_fired = fired;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
      cnt_q <= '0;
    end else if (step_i) begin
      occ_q <= occ_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/debounced_occupancy_toggle_timeout.sv
// Top level: input register, debounce and occupancy logic, result register.
// Depends on dot_pkg, dot_debounce and dot_occupancy.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_stall_o   in_data_i  (dot_in_t)
//   out       output     out_valid_o / out_stall_i out_data_o (dot_out_t)
//   cfg       input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One item per clock sustained while the output is not stalled; an accepted
// item is offered after passing the input register, then the result register.
// A stall on a waiting result holds both registers; in_stall_o follows
// out_stall_i in the same cycle while both registers hold items.
// Reset sets valid flags low, state to released/vacant, config to defaults.
`default_nettype none

module debounced_occupancy_toggle_timeout
  import dot_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire dot_in_t             in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output dot_out_t                 out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers
  logic [DebW-1:0] deb_ticks_q;
  logic [OccW-1:0] timeout_ticks_q;
  dot_lamp_en_t    lamp_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_ticks_q        <= DebTicksRst;
      timeout_ticks_q    <= TimeoutTicksRst;
      lamp_en_q.alarm_en <= 1'b1;
      lamp_en_q.red_en   <= 1'b1;
      lamp_en_q.green_en <= 1'b1;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_DEBOUNCE_TICKS: deb_ticks_q        <= cfg_data_i[DebW-1:0];
        REG_TIMEOUT_TICKS:  timeout_ticks_q    <= cfg_data_i[OccW-1:0];
        REG_ALARM_ENABLE:   lamp_en_q.alarm_en <= cfg_data_i[0];
        REG_RED_ENABLE:     lamp_en_q.red_en   <= cfg_data_i[0];
        REG_GREEN_ENABLE:   lamp_en_q.green_en <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Handshake: the compute step moves the input item into the result register
  logic     in_valid_q;
  dot_in_t  in_data_q;
  logic     out_valid_q;
  dot_out_t out_data_q;
  logic     step;
  logic     in_accept;
  logic     press;
  dot_out_t result;

  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_data_q <= in_data_i;
    end
  end

  dot_debounce u_debounce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .raw_i       (in_data_q.button_level),
    .deb_ticks_i (deb_ticks_q),
    .press_o     (press)
  );

  dot_occupancy u_occupancy (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .press_i         (press),
    .mode_i          (in_data_q.mode),
    .timeout_ticks_i (timeout_ticks_q),
    .lamp_en_i       (lamp_en_q),
    .result_o        (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// File: rtl/core/dot_checker.sv
// Port-level checks for the occupancy block, bound to the top level.
// Depends on dot_pkg and debounced_occupancy_toggle_timeout.
`default_nettype none

module dot_checker
  import dot_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire dot_out_t out_data_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result item changed or dropped");

  // A forced exit leaves the block vacant and announces nothing
  a_timeout_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.timeout_fired |->
      !out_data_o.occupied && (out_data_o.announce == ANN_NONE))
    else $error("timeout item not vacant or carries an announcement");

  // The announcement agrees with the final occupancy
  a_announce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.announce != ANN_NONE) |->
      ((out_data_o.announce == ANN_IN) && out_data_o.occupied) ||
      ((out_data_o.announce == ANN_OUT) && !out_data_o.occupied))
    else $error("announcement disagrees with occupancy");

  // Lamps never contradict occupancy
  a_lamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (!(out_data_o.alarm_out || out_data_o.red_out) || out_data_o.occupied) &&
      (!out_data_o.green_out || !out_data_o.occupied))
    else $error("lamp drive contradicts occupancy");

endmodule

bind debounced_occupancy_toggle_timeout dot_checker u_dot_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
